FILE: design/bipr_pkg.sv
`default_nettype none

package bipr_pkg;

   // Header parse steps.
   localparam logic [3:0] PH_TYPE = 4'd0;
   localparam logic [3:0] PH_BVLC = 4'd1;
   localparam logic [3:0] PH_VER  = 4'd2;
   localparam logic [3:0] PH_CTRL = 4'd3;
   localparam logic [3:0] PH_DNET = 4'd4;
   localparam logic [3:0] PH_DLEN = 4'd5;
   localparam logic [3:0] PH_DADR = 4'd6;
   localparam logic [3:0] PH_SNET = 4'd7;
   localparam logic [3:0] PH_SLEN = 4'd8;
   localparam logic [3:0] PH_SADR = 4'd9;
   localparam logic [3:0] PH_HOP  = 4'd10;
   localparam logic [3:0] PH_APDU = 4'd11;

   // Value decoder steps.
   localparam logic [2:0] VP_SCAN = 3'd0;
   localparam logic [2:0] VP_TAG  = 3'd1;
   localparam logic [2:0] VP_DATA = 3'd2;
   localparam logic [2:0] VP_DONE = 3'd3;
   localparam logic [2:0] VP_FAIL = 3'd4;

   // Frame kinds.
   localparam logic [1:0] KIND_UNRECOGNIZED = 2'd0;
   localparam logic [1:0] KIND_IAM          = 2'd1;
   localparam logic [1:0] KIND_READ_ACK     = 2'd2;
   localparam logic [1:0] KIND_WRITE_ACK    = 2'd3;

   // Value kinds.
   localparam logic [1:0] VKIND_NONE     = 2'd0;
   localparam logic [1:0] VKIND_REAL     = 2'd1;
   localparam logic [1:0] VKIND_UNSIGNED = 2'd2;
   localparam logic [1:0] VKIND_BOOLEAN  = 2'd3;

   // Protocol bytes.
   localparam logic [7:0] BVLC_TYPE_IP      = 8'h81;
   localparam logic [7:0] NET_LAYER_VER     = 8'h01;
   localparam logic [7:0] APDU_UNCONFIRMED  = 8'h10;
   localparam logic [7:0] SERVICE_IAM       = 8'h00;
   localparam logic [7:0] IAM_OBJECT_TAG    = 8'hC4;
   localparam logic [3:0] PDU_SIMPLE_ACK    = 4'h2;
   localparam logic [3:0] PDU_COMPLEX_ACK   = 4'h3;
   localparam logic [7:0] SERVICE_READ_PROP = 8'h0C;
   localparam logic [7:0] SERVICE_WRITE_PROP = 8'h0F;
   localparam logic [7:0] OPENING_TAG_3     = 8'h3E;
   localparam logic [3:0] APP_TAG_BOOLEAN   = 4'd1;
   localparam logic [3:0] APP_TAG_UNSIGNED  = 4'd2;
   localparam logic [3:0] APP_TAG_REAL      = 4'd4;
   localparam logic [3:0] APP_TAG_ENUM      = 4'd9;
   localparam logic [9:0] OBJ_TYPE_DEV      = 10'd8;

   // Control byte flags.
   localparam int CTRL_NETWORK_MSG = 7;
   localparam int CTRL_DEST_PRESENT = 5;
   localparam int CTRL_SRC_PRESENT = 3;

   // One decoded frame result.
   typedef struct packed {
      logic [1:0]  frame_kind;
      logic [21:0] device_instance;
      logic [1:0]  value_kind;
      logic [31:0] value_bits;
   } result_type;

endpackage

`default_nettype wire

FILE: design/bacnet_ip_response_parser_core.sv
`default_nettype none

// BACnet/IP response parser. Frame bytes enter on the req_ channel, one item
// per cycle, the final byte marked by req_last_byte. Each byte is decoded in
// the cycle it is accepted, and the last byte of a frame yields exactly one
// result item, passed through the result queue to rsp_; other bytes yield
// none. The throughput is one byte per clock while the queue has room: the
// header, APDU and value decoders are small state registers updated by one
// level of logic per byte. A two-entry result queue lets bytes keep flowing
// while a result waits; req_stall rises only when both queue entries are
// occupied. The expected invoke id is written through the csr_ port, which
// is always ready, and should only be changed while no frame is in progress.
module bacnet_ip_response_parser_core #(
   parameter int MAX_FRAME_BYTES = 2048
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_frame_byte,
   input  wire         req_last_byte,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [1:0]  rsp_frame_kind,
   output logic [21:0] rsp_device_instance,
   output logic [1:0]  rsp_value_kind,
   output logic [31:0] rsp_value_bits,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [7:0]  csr_expected_invoke_id
);

   localparam int IdxWidth = $clog2(MAX_FRAME_BYTES + 2);
   localparam logic [IdxWidth-1:0] MaxBytes = IdxWidth'(MAX_FRAME_BYTES);
   localparam logic [10:0] ApduPosMax = 11'd2047;

   logic [7:0]          invoke_id_ff;
   logic [IdxWidth-1:0] byte_index_ff, byte_index_in;
   logic [7:0]          npdu_control_ff, npdu_control_in;
   logic [3:0]          header_phase_ff, header_phase_in;
   logic [7:0]          skip_count_ff, skip_count_in;
   logic [10:0]         apdu_position_ff, apdu_position_in;
   logic [7:0]          apdu_type_ff, apdu_type_in;
   logic                ack_header_ok_ff, ack_header_ok_in;
   logic                frame_bad_ff, frame_bad_in;
   logic [2:0]          value_phase_ff, value_phase_in;
   logic [7:0]          value_tag_ff, value_tag_in;
   logic [2:0]          value_seen_ff, value_seen_in;
   logic [31:0]         word_acc_ff, word_acc_in;

   logic                 accept;
   logic                 queue_full;
   bipr_pkg::result_type result;
   bipr_pkg::result_type rsp_data;
   logic [7:0]           b;
   logic [3:0]           type_hi;
   logic [3:0]           tag_num;
   logic [2:0]           tag_len;
   logic [2:0]           seen_next;

   assign accept    = req_valid & ~req_stall;
   assign req_stall = queue_full;
   assign csr_ready = 1'b1;
   assign b         = req_frame_byte;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         invoke_id_ff <= 8'd0;
      end else if (csr_valid && csr_ready) begin
         invoke_id_ff <= csr_expected_invoke_id;
      end
   end

   // Phase that follows the source block.
   function automatic logic [3:0] after_source(input logic [7:0] ctrl);
      return ctrl[bipr_pkg::CTRL_DEST_PRESENT] ? bipr_pkg::PH_HOP : bipr_pkg::PH_APDU;
   endfunction

   // Per-byte decode of header, APDU and value.
   always_comb begin
      byte_index_in    = byte_index_ff;
      npdu_control_in  = npdu_control_ff;
      header_phase_in  = header_phase_ff;
      skip_count_in    = skip_count_ff;
      apdu_position_in = apdu_position_ff;
      apdu_type_in     = apdu_type_ff;
      ack_header_ok_in = ack_header_ok_ff;
      frame_bad_in     = frame_bad_ff;
      value_phase_in   = value_phase_ff;
      value_tag_in     = value_tag_ff;
      value_seen_in    = value_seen_ff;
      word_acc_in      = word_acc_ff;
      type_hi          = apdu_type_ff[7:4];
      tag_num          = b[7:4];
      tag_len          = b[2:0];
      seen_next        = value_seen_ff + 3'd1;

      // Frame length check, saturating one past the limit.
      if (byte_index_ff <= MaxBytes) begin
         byte_index_in = byte_index_ff + IdxWidth'(1);
      end
      if (byte_index_ff >= MaxBytes) begin
         frame_bad_in = 1'b1;
      end

      if (!frame_bad_in) begin
         unique case (header_phase_ff)
            bipr_pkg::PH_TYPE: begin
               if (b != bipr_pkg::BVLC_TYPE_IP) frame_bad_in = 1'b1;
               header_phase_in = bipr_pkg::PH_BVLC;
               skip_count_in   = 8'd3;
            end
            bipr_pkg::PH_BVLC: begin
               skip_count_in = skip_count_ff - 8'd1;
               if (skip_count_ff == 8'd1) header_phase_in = bipr_pkg::PH_VER;
            end
            bipr_pkg::PH_VER: begin
               if (b != bipr_pkg::NET_LAYER_VER) frame_bad_in = 1'b1;
               header_phase_in = bipr_pkg::PH_CTRL;
            end
            bipr_pkg::PH_CTRL: begin
               npdu_control_in = b;
               if (b[bipr_pkg::CTRL_NETWORK_MSG]) frame_bad_in = 1'b1;
               if (b[bipr_pkg::CTRL_DEST_PRESENT]) begin
                  header_phase_in = bipr_pkg::PH_DNET;
                  skip_count_in   = 8'd2;
               end else if (b[bipr_pkg::CTRL_SRC_PRESENT]) begin
                  header_phase_in = bipr_pkg::PH_SNET;
                  skip_count_in   = 8'd2;
               end else begin
                  header_phase_in = after_source(b);
               end
            end
            bipr_pkg::PH_DNET: begin
               skip_count_in = skip_count_ff - 8'd1;
               if (skip_count_ff == 8'd1) header_phase_in = bipr_pkg::PH_DLEN;
            end
            bipr_pkg::PH_DLEN, bipr_pkg::PH_DADR: begin
               // Both end the destination block once the count runs out.
               if (header_phase_ff == bipr_pkg::PH_DLEN) begin
                  skip_count_in = b;
               end else begin
                  skip_count_in = skip_count_ff - 8'd1;
               end
               if (skip_count_in == 8'd0) begin
                  if (npdu_control_ff[bipr_pkg::CTRL_SRC_PRESENT]) begin
                     header_phase_in = bipr_pkg::PH_SNET;
                     skip_count_in   = 8'd2;
                  end else begin
                     header_phase_in = after_source(npdu_control_ff);
                  end
               end else begin
                  header_phase_in = bipr_pkg::PH_DADR;
               end
            end
            bipr_pkg::PH_SNET: begin
               skip_count_in = skip_count_ff - 8'd1;
               if (skip_count_ff == 8'd1) header_phase_in = bipr_pkg::PH_SLEN;
            end
            bipr_pkg::PH_SLEN, bipr_pkg::PH_SADR: begin
               if (header_phase_ff == bipr_pkg::PH_SLEN) begin
                  skip_count_in = b;
               end else begin
                  skip_count_in = skip_count_ff - 8'd1;
               end
               if (skip_count_in == 8'd0) begin
                  header_phase_in = after_source(npdu_control_ff);
               end else begin
                  header_phase_in = bipr_pkg::PH_SADR;
               end
            end
            bipr_pkg::PH_HOP: begin
               header_phase_in = bipr_pkg::PH_APDU;
            end
            bipr_pkg::PH_APDU: begin
               // APDU header: type, invoke id or service, then choice or tag.
               if (apdu_position_ff == 11'd0) begin
                  apdu_type_in = b;
               end else if (apdu_position_ff == 11'd1) begin
                  if (apdu_type_ff == bipr_pkg::APDU_UNCONFIRMED) begin
                     ack_header_ok_in = (b == bipr_pkg::SERVICE_IAM);
                  end else if (type_hi == bipr_pkg::PDU_SIMPLE_ACK ||
                               type_hi == bipr_pkg::PDU_COMPLEX_ACK) begin
                     ack_header_ok_in = (b == invoke_id_ff);
                  end else begin
                     ack_header_ok_in = 1'b0;
                  end
               end else if (apdu_position_ff == 11'd2) begin
                  if (apdu_type_ff == bipr_pkg::APDU_UNCONFIRMED) begin
                     ack_header_ok_in = ack_header_ok_ff && (b == bipr_pkg::IAM_OBJECT_TAG);
                  end else if (type_hi == bipr_pkg::PDU_COMPLEX_ACK) begin
                     ack_header_ok_in = ack_header_ok_ff &&
                                        (b == bipr_pkg::SERVICE_READ_PROP);
                  end else if (type_hi == bipr_pkg::PDU_SIMPLE_ACK) begin
                     ack_header_ok_in = ack_header_ok_ff &&
                                        (b == bipr_pkg::SERVICE_WRITE_PROP);
                  end else begin
                     ack_header_ok_in = 1'b0;
                  end
               end else if (apdu_type_ff == bipr_pkg::APDU_UNCONFIRMED) begin
                  // Collect the four object id bytes of an I-Am.
                  if (apdu_position_ff <= 11'd6) begin
                     word_acc_in = {word_acc_ff[23:0], b};
                  end
               end else if (type_hi == bipr_pkg::PDU_COMPLEX_ACK && ack_header_ok_ff) begin
                  // Value decoder: find the opening tag, then read one value.
                  unique case (value_phase_ff)
                     bipr_pkg::VP_SCAN: begin
                        if (b == bipr_pkg::OPENING_TAG_3) value_phase_in = bipr_pkg::VP_TAG;
                     end
                     bipr_pkg::VP_TAG: begin
                        value_tag_in  = b;
                        word_acc_in   = 32'd0;
                        value_seen_in = 3'd0;
                        if (tag_num == bipr_pkg::APP_TAG_REAL && tag_len == 3'd4) begin
                           value_phase_in = bipr_pkg::VP_DATA;
                        end else if ((tag_num == bipr_pkg::APP_TAG_UNSIGNED ||
                                      tag_num == bipr_pkg::APP_TAG_ENUM) &&
                                     tag_len >= 3'd1 && tag_len <= 3'd4) begin
                           value_phase_in = bipr_pkg::VP_DATA;
                        end else if (tag_num == bipr_pkg::APP_TAG_BOOLEAN) begin
                           word_acc_in    = {31'd0, tag_len != 3'd0};
                           value_phase_in = bipr_pkg::VP_DONE;
                        end else begin
                           value_phase_in = bipr_pkg::VP_FAIL;
                        end
                     end
                     bipr_pkg::VP_DATA: begin
                        word_acc_in   = {word_acc_ff[23:0], b};
                        value_seen_in = seen_next;
                        if (seen_next >= value_tag_ff[2:0]) begin
                           value_phase_in = bipr_pkg::VP_DONE;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               if (apdu_position_ff < ApduPosMax) begin
                  apdu_position_in = apdu_position_ff + 11'd1;
               end
            end
            default: begin
               frame_bad_in = 1'b1;
            end
         endcase
      end
   end

   // Classification of the frame from the state after its last byte.
   always_comb begin
      result = '0;
      if (!frame_bad_in && header_phase_in == bipr_pkg::PH_APDU &&
          apdu_position_in != 11'd0 && ack_header_ok_in) begin
         if (apdu_type_in == bipr_pkg::APDU_UNCONFIRMED) begin
            if (apdu_position_in >= 11'd8 &&
                word_acc_in[31:22] == bipr_pkg::OBJ_TYPE_DEV) begin
               result.frame_kind      = bipr_pkg::KIND_IAM;
               result.device_instance = word_acc_in[21:0];
            end
         end else if (apdu_type_in[7:4] == bipr_pkg::PDU_COMPLEX_ACK) begin
            if (apdu_position_in >= 11'd4 && value_phase_in == bipr_pkg::VP_DONE) begin
               result.frame_kind = bipr_pkg::KIND_READ_ACK;
               result.value_bits = word_acc_in;
               if (value_tag_in[7:4] == bipr_pkg::APP_TAG_REAL) begin
                  result.value_kind = bipr_pkg::VKIND_REAL;
               end else if (value_tag_in[7:4] == bipr_pkg::APP_TAG_BOOLEAN) begin
                  result.value_kind = bipr_pkg::VKIND_BOOLEAN;
               end else begin
                  result.value_kind = bipr_pkg::VKIND_UNSIGNED;
               end
            end
         end else if (apdu_type_in[7:4] == bipr_pkg::PDU_SIMPLE_ACK) begin
            if (apdu_position_in >= 11'd3) result.frame_kind = bipr_pkg::KIND_WRITE_ACK;
         end
      end
   end

   // Frame state: updated on each item, cleared after the last byte.
   always_ff @(posedge clock) begin
      if (reset || (accept && req_last_byte)) begin
         byte_index_ff    <= '0;
         npdu_control_ff  <= 8'd0;
         header_phase_ff  <= bipr_pkg::PH_TYPE;
         skip_count_ff    <= 8'd0;
         apdu_position_ff <= 11'd0;
         apdu_type_ff     <= 8'd0;
         ack_header_ok_ff <= 1'b0;
         frame_bad_ff     <= 1'b0;
         value_phase_ff   <= bipr_pkg::VP_SCAN;
         value_tag_ff     <= 8'd0;
         value_seen_ff    <= 3'd0;
         word_acc_ff      <= 32'd0;
      end else if (accept) begin
         byte_index_ff    <= byte_index_in;
         npdu_control_ff  <= npdu_control_in;
         header_phase_ff  <= header_phase_in;
         skip_count_ff    <= skip_count_in;
         apdu_position_ff <= apdu_position_in;
         apdu_type_ff     <= apdu_type_in;
         ack_header_ok_ff <= ack_header_ok_in;
         frame_bad_ff     <= frame_bad_in;
         value_phase_ff   <= value_phase_in;
         value_tag_ff     <= value_tag_in;
         value_seen_ff    <= value_seen_in;
         word_acc_ff      <= word_acc_in;
      end
   end

   bipr_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept & req_last_byte),
      .push_data (result),
      .full      (queue_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_frame_kind      = rsp_data.frame_kind;
   assign rsp_device_instance = rsp_data.device_instance;
   assign rsp_value_kind      = rsp_data.value_kind;
   assign rsp_value_bits      = rsp_data.value_bits;

endmodule

`default_nettype wire

FILE: design/bipr_rsp_queue.sv
`default_nettype none

// Two-entry result queue: a head register that drives the port and a skid
// register that catches a result while the head is stalled.
module bipr_rsp_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  wire bipr_pkg::result_type push_data,
   output logic                 full,
   output logic                 out_valid,
   input  wire                  out_stall,
   output bipr_pkg::result_type out_data
);

   logic                 head_valid_ff, head_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   bipr_pkg::result_type head_data_ff, head_data_in;
   bipr_pkg::result_type skid_data_ff, skid_data_in;
   logic                 pop;

   assign pop = head_valid_ff & ~out_stall;

   // Drain first, then fill the first free slot.
   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_data_in  = head_data_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            head_valid_in = 1'b0;
         end
      end
      if (push) begin
         if (!head_valid_in) begin
            head_valid_in = 1'b1;
            head_data_in  = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_data_ff <= head_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = head_valid_ff;
   assign out_data  = head_data_ff;

   // A result is never pushed into a full queue.
   assert property (@(posedge clock) disable iff (reset) push |-> !skid_valid_ff)
      else $error("result pushed into a full queue");

   // The skid slot only holds an item behind a valid head.
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> head_valid_ff)
      else $error("skid slot valid with empty head");

   // A lone head that drains with nothing arriving leaves the queue empty.
   assert property (@(posedge clock) disable iff (reset)
      (pop && !push && !skid_valid_ff) |=> !head_valid_ff)
      else $error("head still valid after draining");

endmodule

`default_nettype wire
